/* hdl/swqf_pkg.sv */
// ============================================================================
// swqf_pkg: shared types and constants for the sliding window quadratic fit
// Holds the wide integer type used by the fit arithmetic, status codes,
// register indexes and the limb length helper.
// ============================================================================
package swqf_pkg;

    // Wide two's complement integers: ten limbs of 32 bits, arithmetic wraps.
    localparam int LIMB_W     = 32;
    localparam int LIMBS      = 10;
    localparam int BIG_W      = LIMB_W * LIMBS;
    localparam int LIMB_CNT_W = $clog2(LIMBS + 1);

    typedef logic [BIG_W-1:0] t_big;

    // Default ring depth.
    localparam int MAX_WINDOW_DEF = 64;

    // Configuration register map.
    localparam logic       REG_WINDOW   = 1'b0;
    localparam logic [6:0] WINDOW_RESET = 7'd8;

    // Result status codes.
    localparam logic [1:0] ST_NOT_PRIMED = 2'd0;
    localparam logic [1:0] ST_FIT_VALID  = 2'd1;
    localparam logic [1:0] ST_DET_ZERO   = 2'd2;

    // Number of limbs up to and including the highest nonzero one.
    function automatic logic [LIMB_CNT_W-1:0] big_len(input t_big v);
        logic [LIMB_CNT_W-1:0] len;
        len = '0;
        for (int k = 0; k < LIMBS; k++) begin
            if (v[k*LIMB_W +: LIMB_W] != '0) begin
                len = LIMB_CNT_W'(k + 1);
            end
        end
        return len;
    endfunction

endpackage

/* hdl/swqf_bigmul.sv */
// ============================================================================
// swqf_bigmul: wide multiplier, product modulo 2**BIG_W
// Multiplies magnitudes limb by limb with one 32x32 product per cycle and
// applies the sign at the end. Limbs above the highest nonzero one are skipped.
// ============================================================================
module swqf_bigmul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  swqf_pkg::t_big     i_a,
    input  swqf_pkg::t_big     i_b,
    output logic               o_done,
    output swqf_pkg::t_big     o_prod
);

    localparam int LW = swqf_pkg::LIMB_W;
    localparam int NL = swqf_pkg::LIMBS;
    localparam int BW = swqf_pkg::BIG_W;
    localparam int CW = swqf_pkg::LIMB_CNT_W;

    typedef enum logic [2:0] {M_IDLE, M_LEN, M_RUN, M_DRAIN, M_FIN} t_mstate;

    t_mstate          r_state;
    swqf_pkg::t_big   r_ma;
    swqf_pkg::t_big   r_mb;
    swqf_pkg::t_big   r_acc;
    swqf_pkg::t_big   r_prod;
    logic             r_neg;
    logic             r_done;
    logic [CW-1:0]    r_la;
    logic [CW-1:0]    r_lb;
    logic [CW-1:0]    r_i;
    logic [CW-1:0]    r_j;
    logic [CW-1:0]    r_k;
    logic [2*LW-1:0]  r_pp;
    logic             r_pp_v;

    logic [CW-1:0]    w_la;
    logic [CW-1:0]    w_lb;
    logic             w_last_j;
    logic             w_last_i;

    // Operand lengths in limbs and loop end conditions.
    always_comb begin
        w_la     = swqf_pkg::big_len(r_ma);
        w_lb     = swqf_pkg::big_len(r_mb);
        w_last_j = (int'(r_j) + 1 >= int'(r_lb)) || (int'(r_i) + int'(r_j) + 1 >= NL);
        w_last_i = (int'(r_i) + 1 >= int'(r_la)) || (int'(r_i) + 1 >= NL);
    end

    // Sequencer, partial product register and accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_pp_v  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_pp_v) begin
                r_acc <= r_acc + (BW'(r_pp) << (int'(r_k) * LW));
            end
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_ma    <= i_a[BW-1] ? -i_a : i_a;
                        r_mb    <= i_b[BW-1] ? -i_b : i_b;
                        r_neg   <= i_a[BW-1] ^ i_b[BW-1];
                        r_state <= M_LEN;
                    end
                end
                M_LEN: begin
                    r_la  <= w_la;
                    r_lb  <= w_lb;
                    r_i   <= '0;
                    r_j   <= '0;
                    r_acc <= '0;
                    if (w_la != '0 && w_lb != '0) begin
                        r_state <= M_RUN;
                    end else begin
                        r_state <= M_FIN;
                    end
                end
                M_RUN: begin
                    r_pp   <= r_ma[int'(r_i)*LW +: LW] * r_mb[int'(r_j)*LW +: LW];
                    r_k    <= r_i + r_j;
                    r_pp_v <= 1'b1;
                    if (w_last_j) begin
                        r_j <= '0;
                        if (w_last_i) begin
                            r_state <= M_DRAIN;
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                M_DRAIN: begin
                    r_pp_v  <= 1'b0;
                    r_state <= M_FIN;
                end
                M_FIN: begin
                    r_prod  <= r_neg ? -r_acc : r_acc;
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

/* hdl/swqf_rdiv.sv */
// ============================================================================
// swqf_rdiv: rounded signed division with 64-bit saturation
// Computes round(num/den), halves away from zero, by restoring division of
// (2|num|+|den|) by 2|den|, one quotient bit per cycle.
// ============================================================================
module swqf_rdiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  swqf_pkg::t_big      i_num,
    input  swqf_pkg::t_big      i_den,
    output logic                o_done,
    output logic signed [63:0]  o_quot
);

    localparam int LW  = swqf_pkg::LIMB_W;
    localparam int NL  = swqf_pkg::LIMBS;
    localparam int BW  = swqf_pkg::BIG_W;
    localparam int CW  = swqf_pkg::LIMB_CNT_W;
    localparam int BCW = $clog2(BW + 1);

    typedef enum logic [2:0] {D_IDLE, D_ABS, D_ALIGN, D_RUN, D_FIN} t_dstate;

    t_dstate              r_state;
    swqf_pkg::t_big       r_an;
    swqf_pkg::t_big       r_ad;
    swqf_pkg::t_big       r_n;
    swqf_pkg::t_big       r_d;
    swqf_pkg::t_big       r_r;
    swqf_pkg::t_big       r_q;
    logic                 r_neg;
    logic [BCW-1:0]       r_cnt;
    logic                 r_done;
    logic signed [63:0]   r_quot;

    logic [CW-1:0]        w_top;
    swqf_pkg::t_big       w_rem;
    logic                 w_ge;
    logic                 w_big;
    logic [63:0]          w_mag;

    // Partial remainder step and final saturation check.
    always_comb begin
        w_top = swqf_pkg::big_len(r_n);
        w_rem = {r_r[BW-2:0], r_n[BW-1]};
        w_ge  = (w_rem >= r_d);
        w_big = r_q[63] || (r_q[BW-1:64] != '0);
        w_mag = r_q[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_an    <= i_num[BW-1] ? -i_num : i_num;
                        r_ad    <= i_den[BW-1] ? -i_den : i_den;
                        r_neg   <= i_num[BW-1] ^ i_den[BW-1];
                        r_state <= D_ABS;
                    end
                end
                D_ABS: begin
                    r_n     <= r_an + r_an + r_ad;
                    r_d     <= r_ad + r_ad;
                    r_state <= D_ALIGN;
                end
                D_ALIGN: begin
                    // Leading zero limbs of the dividend give zero quotient bits.
                    r_r <= '0;
                    r_q <= '0;
                    if (r_d == '0) begin
                        r_cnt   <= BCW'(BW);
                        r_state <= D_RUN;
                    end else if (w_top == '0) begin
                        r_state <= D_FIN;
                    end else begin
                        r_n     <= r_n << ((NL - int'(w_top)) * LW);
                        r_cnt   <= BCW'(int'(w_top) * LW);
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_r     <= w_ge ? (w_rem - r_d) : w_rem;
                    r_q     <= {r_q[BW-2:0], w_ge};
                    r_n     <= {r_n[BW-2:0], 1'b0};
                    r_cnt   <= r_cnt - BCW'(1);
                    if (r_cnt == BCW'(1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    if (w_big) begin
                        r_quot <= r_neg ? 64'sh8000_0000_0000_0000
                                        : 64'sh7FFF_FFFF_FFFF_FFFF;
                    end else begin
                        r_quot <= r_neg ? -$signed(w_mag) : $signed(w_mag);
                    end
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* hdl/sliding_window_quadratic_fit.sv */
// ============================================================================
// sliding_window_quadratic_fit: least-squares quadratic fit over a sample ring
// Stores each sample in a ring memory and, after more than window_length samples,
// fits position, velocity and acceleration over the newest window_length samples.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_sample_value, i_step_ticks
//   out      output     o_out_valid / i_out_stall o_fit_status, o_fit_position,
//                                                 o_fit_velocity, o_fit_acceleration
//   config   input      APB psel/penable/pready   window_length at address 0
//
// An item that does not complete the window goes straight to the result. A fit
// walks the windowed samples with one ring read and five limb-serial products
// each in the shared wide multiplier, then the closing products, then three
// divisions at one quotient bit per cycle. One item is in work at a time; the
// result register lets the next item enter while a result waits. Reset is
// synchronous; the ring needs no clearing pass.
// ============================================================================
module sliding_window_quadratic_fit #(
    parameter int MAX_WINDOW = swqf_pkg::MAX_WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_sample_value,
    input  logic [15:0]        i_step_ticks,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_fit_status,
    output logic signed [63:0] o_fit_position,
    output logic signed [63:0] o_fit_velocity,
    output logic signed [63:0] o_fit_acceleration,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int BW     = swqf_pkg::BIG_W;
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 2);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_SAMPLE, S_MUL, S_CHECK, S_DIV, S_RESULT
    } t_state;

    typedef enum logic [4:0] {
        OP_X2, OP_X3, OP_X4, OP_XY, OP_X2Y,
        OP_E2A, OP_E2B, OP_E3A, OP_E3B, OP_E4A, OP_E4B,
        OP_EXYA, OP_EXYB, OP_EX2YA, OP_EX2YB, OP_DENA, OP_DENB,
        OP_ANA, OP_ANB, OP_BNA, OP_BNB, OP_CNA, OP_CNB, OP_CNC, OP_DN
    } t_op;

    typedef enum logic [1:0] {DV_POS, DV_VEL, DV_ACC} t_div;

    // Control state.
    t_state              r_state;
    t_op                 r_op;
    t_div                r_div_sel;
    logic                r_mul_busy;
    logic                r_div_busy;
    logic [6:0]          r_window;
    logic [CNT_W-1:0]    r_count;
    logic [SLOT_W-1:0]   r_wslot;
    logic [SLOT_W-1:0]   r_slot;
    logic [WIN_W-1:0]    r_idx;
    logic                r_out_valid;

    // Ring memory of {value, step}.
    logic [47:0]         r_ring [MAX_WINDOW];
    logic [47:0]         r_rdata;

    // Fit datapath.
    logic signed [31:0]  r_x;
    logic signed [31:0]  r_y;
    logic [15:0]         r_step;
    swqf_pkg::t_big      r_x2;
    swqf_pkg::t_big      r_s1;
    swqf_pkg::t_big      r_s2;
    swqf_pkg::t_big      r_s3;
    swqf_pkg::t_big      r_s4;
    swqf_pkg::t_big      r_sy;
    swqf_pkg::t_big      r_sxy;
    swqf_pkg::t_big      r_sx2y;
    swqf_pkg::t_big      r_e2;
    swqf_pkg::t_big      r_e3;
    swqf_pkg::t_big      r_e4;
    swqf_pkg::t_big      r_exy;
    swqf_pkg::t_big      r_ex2y;
    swqf_pkg::t_big      r_den;
    swqf_pkg::t_big      r_an;
    swqf_pkg::t_big      r_bn;
    swqf_pkg::t_big      r_cn;
    swqf_pkg::t_big      r_dn;

    // Result holding and output registers.
    logic [1:0]          r_res_status;
    logic signed [63:0]  r_res_pos;
    logic signed [63:0]  r_res_vel;
    logic signed [63:0]  r_res_acc;
    logic [1:0]          r_fit_status;
    logic signed [63:0]  r_fit_position;
    logic signed [63:0]  r_fit_velocity;
    logic signed [63:0]  r_fit_acceleration;

    logic [WIN_W-1:0]    w_n;
    logic [SLOT_W-1:0]   w_ws;
    logic [SLOT_W-1:0]   n_wslot;
    logic [CNT_W-1:0]    n_count;
    logic                w_primed;
    logic                w_in_acc;
    logic                w_cfg_wr;
    swqf_pkg::t_big      w_xb;
    swqf_pkg::t_big      w_yb;
    swqf_pkg::t_big      w_rdy;
    swqf_pkg::t_big      w_nb;
    swqf_pkg::t_big      w_mul_a;
    swqf_pkg::t_big      w_mul_b;
    swqf_pkg::t_big      w_prod;
    logic                w_mul_start;
    logic                w_mul_done;
    swqf_pkg::t_big      w_div_num;
    swqf_pkg::t_big      w_div_den;
    logic                w_div_start;
    logic                w_div_done;
    logic signed [63:0]  w_quot;

    // Window in use, write slot and fill count.
    always_comb begin
        if (r_window == '0) begin
            w_n = WIN_W'(1);
        end else if (int'(r_window) > MAX_WINDOW) begin
            w_n = WIN_W'(MAX_WINDOW);
        end else begin
            w_n = WIN_W'(r_window);
        end
        w_ws = (WIN_W'(r_wslot) < w_n) ? r_wslot : '0;
        if (WIN_W'(w_ws) + WIN_W'(1) == w_n) begin
            n_wslot = '0;
        end else begin
            n_wslot = w_ws + SLOT_W'(1);
        end
        n_count  = (r_count < CNT_W'(w_n) + CNT_W'(1)) ? r_count + CNT_W'(1) : r_count;
        w_primed = (n_count > CNT_W'(w_n));
        w_in_acc = i_in_valid && (r_state == S_IDLE);
        w_cfg_wr = psel && penable && pwrite && (paddr[2] == swqf_pkg::REG_WINDOW);
    end

    // Sign and zero extension into the wide format.
    always_comb begin
        w_xb  = {{(BW-32){r_x[31]}}, r_x};
        w_yb  = {{(BW-32){r_y[31]}}, r_y};
        w_rdy = {{(BW-32){r_rdata[47]}}, r_rdata[47:16]};
        w_nb  = BW'(w_n);
    end

    // Multiplier operands for each step of the fit.
    always_comb begin
        case (r_op)
            OP_X2:    begin w_mul_a = w_xb;   w_mul_b = w_xb;   end
            OP_X3:    begin w_mul_a = r_x2;   w_mul_b = w_xb;   end
            OP_X4:    begin w_mul_a = r_x2;   w_mul_b = r_x2;   end
            OP_XY:    begin w_mul_a = w_xb;   w_mul_b = w_yb;   end
            OP_X2Y:   begin w_mul_a = r_x2;   w_mul_b = w_yb;   end
            OP_E2A:   begin w_mul_a = w_nb;   w_mul_b = r_s2;   end
            OP_E2B:   begin w_mul_a = r_s1;   w_mul_b = r_s1;   end
            OP_E3A:   begin w_mul_a = w_nb;   w_mul_b = r_s3;   end
            OP_E3B:   begin w_mul_a = r_s1;   w_mul_b = r_s2;   end
            OP_E4A:   begin w_mul_a = w_nb;   w_mul_b = r_s4;   end
            OP_E4B:   begin w_mul_a = r_s2;   w_mul_b = r_s2;   end
            OP_EXYA:  begin w_mul_a = w_nb;   w_mul_b = r_sxy;  end
            OP_EXYB:  begin w_mul_a = r_s1;   w_mul_b = r_sy;   end
            OP_EX2YA: begin w_mul_a = w_nb;   w_mul_b = r_sx2y; end
            OP_EX2YB: begin w_mul_a = r_s2;   w_mul_b = r_sy;   end
            OP_DENA:  begin w_mul_a = r_e2;   w_mul_b = r_e4;   end
            OP_DENB:  begin w_mul_a = r_e3;   w_mul_b = r_e3;   end
            OP_ANA:   begin w_mul_a = r_ex2y; w_mul_b = r_e2;   end
            OP_ANB:   begin w_mul_a = r_exy;  w_mul_b = r_e3;   end
            OP_BNA:   begin w_mul_a = r_exy;  w_mul_b = r_e4;   end
            OP_BNB:   begin w_mul_a = r_ex2y; w_mul_b = r_e3;   end
            OP_CNA:   begin w_mul_a = r_sy;   w_mul_b = r_den;  end
            OP_CNB:   begin w_mul_a = r_bn;   w_mul_b = r_s1;   end
            OP_CNC:   begin w_mul_a = r_an;   w_mul_b = r_s2;   end
            OP_DN:    begin w_mul_a = w_nb;   w_mul_b = r_den;  end
            default:  begin w_mul_a = '0;     w_mul_b = '0;     end
        endcase
        w_mul_start = (r_state == S_MUL) && !r_mul_busy;
    end

    // Divider operands: Q16.16 inputs scaled up to Q32.32 results.
    always_comb begin
        case (r_div_sel)
            DV_POS:  begin w_div_num = {r_cn[BW-17:0], 16'b0}; w_div_den = r_dn;  end
            DV_VEL:  begin w_div_num = {r_bn[BW-17:0], 16'b0}; w_div_den = r_den; end
            DV_ACC:  begin w_div_num = {r_an[BW-18:0], 17'b0}; w_div_den = r_den; end
            default: begin w_div_num = '0;                     w_div_den = r_den; end
        endcase
        w_div_start = (r_state == S_DIV) && !r_div_busy;
    end

    swqf_bigmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    swqf_rdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Sample ring: written on accept, read in the cycle after the slot is set.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ring[w_ws] <= {i_sample_value, i_step_ticks};
        end
        r_rdata <= r_ring[r_slot];
    end

    // Main sequencer with its datapath and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_X2;
            r_div_sel   <= DV_POS;
            r_mul_busy  <= 1'b0;
            r_div_busy  <= 1'b0;
            r_window    <= swqf_pkg::WINDOW_RESET;
            r_count     <= '0;
            r_wslot     <= '0;
            r_slot      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A taken result empties the output unless a new one loads now.
            if (r_out_valid && !i_out_stall && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_wslot <= n_wslot;
                        r_count <= n_count;
                        if (!w_primed) begin
                            r_res_status <= swqf_pkg::ST_NOT_PRIMED;
                            r_res_pos    <= '0;
                            r_res_vel    <= '0;
                            r_res_acc    <= '0;
                            r_state      <= S_RESULT;
                        end else begin
                            r_slot  <= w_ws;
                            r_idx   <= '0;
                            r_x     <= '0;
                            r_s1    <= '0;
                            r_s2    <= '0;
                            r_s3    <= '0;
                            r_s4    <= '0;
                            r_sy    <= '0;
                            r_sxy   <= '0;
                            r_sx2y  <= '0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_SAMPLE;
                end
                S_SAMPLE: begin
                    // Newest-first walk: value of this slot, step for the next x.
                    r_y        <= $signed(r_rdata[47:16]);
                    r_step     <= r_rdata[15:0];
                    r_s1       <= r_s1 + w_xb;
                    r_sy       <= r_sy + w_rdy;
                    r_op       <= OP_X2;
                    r_mul_busy <= 1'b0;
                    r_state    <= S_MUL;
                end
                S_MUL: begin
                    if (!r_mul_busy) begin
                        r_mul_busy <= 1'b1;
                    end else if (w_mul_done) begin
                        r_mul_busy <= 1'b0;
                        case (r_op)
                            OP_X2: begin
                                r_x2 <= w_prod;
                                r_s2 <= r_s2 + w_prod;
                                r_op <= OP_X3;
                            end
                            OP_X3:    begin r_s3 <= r_s3 + w_prod;    r_op <= OP_X4;    end
                            OP_X4:    begin r_s4 <= r_s4 + w_prod;    r_op <= OP_XY;    end
                            OP_XY:    begin r_sxy <= r_sxy + w_prod;  r_op <= OP_X2Y;   end
                            OP_X2Y: begin
                                r_sx2y <= r_sx2y + w_prod;
                                if (r_idx + WIN_W'(1) == w_n) begin
                                    r_op <= OP_E2A;
                                end else begin
                                    r_idx   <= r_idx + WIN_W'(1);
                                    r_x     <= r_x - $signed({16'b0, r_step});
                                    r_slot  <= (r_slot == '0) ? SLOT_W'(w_n - WIN_W'(1))
                                                              : r_slot - SLOT_W'(1);
                                    r_state <= S_READ;
                                end
                            end
                            OP_E2A:   begin r_e2 <= w_prod;           r_op <= OP_E2B;   end
                            OP_E2B:   begin r_e2 <= r_e2 - w_prod;    r_op <= OP_E3A;   end
                            OP_E3A:   begin r_e3 <= w_prod;           r_op <= OP_E3B;   end
                            OP_E3B:   begin r_e3 <= r_e3 - w_prod;    r_op <= OP_E4A;   end
                            OP_E4A:   begin r_e4 <= w_prod;           r_op <= OP_E4B;   end
                            OP_E4B:   begin r_e4 <= r_e4 - w_prod;    r_op <= OP_EXYA;  end
                            OP_EXYA:  begin r_exy <= w_prod;          r_op <= OP_EXYB;  end
                            OP_EXYB:  begin r_exy <= r_exy - w_prod;  r_op <= OP_EX2YA; end
                            OP_EX2YA: begin r_ex2y <= w_prod;         r_op <= OP_EX2YB; end
                            OP_EX2YB: begin r_ex2y <= r_ex2y - w_prod; r_op <= OP_DENA; end
                            OP_DENA:  begin r_den <= w_prod;          r_op <= OP_DENB;  end
                            OP_DENB: begin
                                r_den   <= r_den - w_prod;
                                r_state <= S_CHECK;
                            end
                            OP_ANA:   begin r_an <= w_prod;           r_op <= OP_ANB;   end
                            OP_ANB:   begin r_an <= r_an - w_prod;    r_op <= OP_BNA;   end
                            OP_BNA:   begin r_bn <= w_prod;           r_op <= OP_BNB;   end
                            OP_BNB:   begin r_bn <= r_bn - w_prod;    r_op <= OP_CNA;   end
                            OP_CNA:   begin r_cn <= w_prod;           r_op <= OP_CNB;   end
                            OP_CNB:   begin r_cn <= r_cn - w_prod;    r_op <= OP_CNC;   end
                            OP_CNC:   begin r_cn <= r_cn - w_prod;    r_op <= OP_DN;    end
                            OP_DN: begin
                                r_dn       <= w_prod;
                                r_div_sel  <= DV_POS;
                                r_div_busy <= 1'b0;
                                r_state    <= S_DIV;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    // Fewer than three distinct times leave the system singular.
                    if (r_den == '0) begin
                        r_res_status <= swqf_pkg::ST_DET_ZERO;
                        r_res_pos    <= '0;
                        r_res_vel    <= '0;
                        r_res_acc    <= '0;
                        r_state      <= S_RESULT;
                    end else begin
                        r_op    <= OP_ANA;
                        r_state <= S_MUL;
                    end
                end
                S_DIV: begin
                    if (!r_div_busy) begin
                        r_div_busy <= 1'b1;
                    end else if (w_div_done) begin
                        r_div_busy <= 1'b0;
                        case (r_div_sel)
                            DV_POS: begin
                                r_res_pos <= w_quot;
                                r_div_sel <= DV_VEL;
                            end
                            DV_VEL: begin
                                r_res_vel <= w_quot;
                                r_div_sel <= DV_ACC;
                            end
                            DV_ACC: begin
                                r_res_acc    <= w_quot;
                                r_res_status <= swqf_pkg::ST_FIT_VALID;
                                r_state      <= S_RESULT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_fit_status       <= r_res_status;
                        r_fit_position     <= r_res_pos;
                        r_fit_velocity     <= r_res_vel;
                        r_fit_acceleration <= r_res_acc;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // Window write restarts filling.
            if (w_cfg_wr) begin
                r_window <= pwdata[6:0];
                r_count  <= '0;
                r_wslot  <= '0;
            end
        end
    end

    // Ports.
    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_fit_status       = r_fit_status;
    assign o_fit_position     = r_fit_position;
    assign o_fit_velocity     = r_fit_velocity;
    assign o_fit_acceleration = r_fit_acceleration;
    assign prdata             = (paddr[2] == swqf_pkg::REG_WINDOW) ? {25'b0, r_window} : '0;
    assign pready             = 1'b1;

endmodule
